### rtl/core/gble_pkg.sv
// ----------------------------------------------------------------------------
// gble_pkg
// Shared types and constants of the gap buffer line engine.
// ----------------------------------------------------------------------------
package gble_pkg;

  // Default sizes of the text memory and of the get-line output window.
  localparam int unsigned BufferBytesDef = 4096;
  localparam int unsigned MaxLineOutDef  = 64;

  // Widths of the item fields.
  localparam int unsigned OpW   = 3;
  localparam int unsigned PosW  = 13;
  localparam int unsigned MaxW  = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 6;

  // Line break character.
  localparam logic [ByteW-1:0] NewlineByte = 8'h0A;

  // Operation codes carried by an input item.
  typedef enum logic [OpW-1:0] {
    OP_INIT    = 3'd0,
    OP_INSERT  = 3'd1,
    OP_MOVE    = 3'd2,
    OP_RANGE   = 3'd3,
    OP_GETLINE = 3'd4,
    OP_RECOUNT = 3'd5,
    OP_CURSOR  = 3'd6
  } op_e;

endpackage

### rtl/core/gap_buffer_line_engine.sv
// ----------------------------------------------------------------------------
// gap_buffer_line_engine
// Text held as a gap buffer in one memory, with line lookup, line readout,
// line counting and cursor tracking, run by a byte-serial sequencer.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+--------------------------------------
//   input   | in_valid_i / in_stall_o | opcode, target_position, row_number,
//           |                         | max_length, char_in
//   output  | out_valid_o/out_stall_i | line fields, char fields, status
//
// One item at a time. Init, insert and unused codes go straight to the
// output register. Move steps one byte across the gap per read state and
// write state; line range, get line, recount and cursor scan one text byte
// per read state and evaluate state (up to text length plus one), as the
// memory has a single registered read port. Get line then emits each byte
// through a read state, a load state and the output register. Each result
// waits in the output register while out_stall_i is high. Reset clears the
// gap to the whole memory; the memory contents are not cleared.
module gap_buffer_line_engine #(
  parameter int unsigned BUFFER_BYTES = gble_pkg::BufferBytesDef,
  parameter int unsigned MAX_LINE_OUT = gble_pkg::MaxLineOutDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gble_pkg::OpW-1:0]    opcode_i,
  input  logic [gble_pkg::PosW-1:0]   target_position_i,
  input  logic [gble_pkg::PosW-1:0]   row_number_i,
  input  logic [gble_pkg::MaxW-1:0]   max_length_i,
  input  logic [gble_pkg::ByteW-1:0]  char_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        line_found_o,
  output logic [gble_pkg::PosW-1:0]   line_begin_o,
  output logic [gble_pkg::PosW-1:0]   line_finish_o,
  output logic [gble_pkg::ByteW-1:0]  char_out_o,
  output logic                        char_valid_o,
  output logic [gble_pkg::LenW-1:0]   line_length_o,
  output logic                        last_o,
  output logic [gble_pkg::PosW-1:0]   cursor_row_o,
  output logic [gble_pkg::PosW-1:0]   cursor_col_o,
  output logic [gble_pkg::PosW-1:0]   line_total_o,
  output logic [gble_pkg::PosW-1:0]   gap_position_o,
  output logic                        buffer_full_o
);

  // Positions and counts hold up to the buffer size plus one.
  localparam int unsigned PW = $clog2(BUFFER_BYTES + 2);
  localparam int unsigned IW = $clog2(BUFFER_BYTES);
  localparam int unsigned XW = (PW > gble_pkg::PosW) ? PW : gble_pkg::PosW;
  localparam int unsigned LW = gble_pkg::LenW;
  localparam logic [PW-1:0] BufSize = PW'(BUFFER_BYTES);
  localparam logic [XW-1:0] OutCap  = XW'(MAX_LINE_OUT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_EMIT_RD,
    S_EMIT_LD,
    S_OUT
  } state_e;

  state_e            state_q;
  gble_pkg::op_e     op_q;
  logic [PW-1:0]     gap_first_q, gap_past_q, tally_q, row_q, col_q;
  logic [PW-1:0]     tgt_q, li_q, cnt_q, start_q, begin_q, finish_q;
  logic [gble_pkg::PosW-1:0] row_num_q;
  logic [gble_pkg::MaxW-1:0] max_len_q;
  logic [LW-1:0]     j_q, len_q;
  logic              found_q, cvalid_q, last_q, full_q, out_valid_q;
  logic [gble_pkg::ByteW-1:0] char_q;

  logic [PW-1:0]     text_len, gap_size, look_pos, phys_pos, span, tgt_in;
  logic [XW-1:0]     lim, cap;
  logic              brk, accept;
  logic              wr_en;
  logic [IW-1:0]     wr_addr, rd_addr;
  logic [gble_pkg::ByteW-1:0] wr_data, rd_data;

  // Text length, gap size and logical to physical address mapping.
  assign gap_size = gap_past_q - gap_first_q;
  assign text_len = BufSize - gap_size;
  assign look_pos = (state_q == S_EMIT_RD) ? (begin_q + PW'(j_q)) : li_q;
  assign phys_pos = (look_pos < gap_first_q) ? look_pos : (look_pos + gap_size);
  assign brk      = (li_q == text_len) || (rd_data == gble_pkg::NewlineByte);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign tgt_in   = (XW'(target_position_i) > XW'(text_len)) ? text_len
                                                              : PW'(target_position_i);

  // Get-line byte count: span capped by max_length minus one and window size minus one.
  assign span = li_q - start_q;
  always_comb begin
    lim = (max_len_q == '0) ? '0 : XW'(max_len_q - 1'b1);
    if (lim > OutCap) begin
      lim = OutCap;
    end
    cap = (XW'(span) < lim) ? XW'(span) : lim;
  end

  // Memory port control.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = gap_first_q[IW-1:0];
    wr_data = char_in_i;
    rd_addr = phys_pos[IW-1:0];
    if (accept && (gble_pkg::op_e'(opcode_i) == gble_pkg::OP_INSERT)
        && (gap_first_q < gap_past_q)) begin
      wr_en = 1'b1;
    end
    if (state_q == S_MOVE_RD) begin
      rd_addr = (tgt_q < gap_first_q) ? IW'(gap_first_q - 1'b1) : gap_past_q[IW-1:0];
    end
    if (state_q == S_MOVE_WR) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
      wr_addr = (tgt_q < gap_first_q) ? IW'(gap_past_q - 1'b1) : gap_first_q[IW-1:0];
    end
  end

  gble_text_ram #(
    .Depth (BUFFER_BYTES),
    .AddrW (IW)
  ) u_text_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer with the buffer state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= gble_pkg::OP_INIT;
      gap_first_q <= '0;
      gap_past_q  <= BufSize;
      tally_q     <= PW'(1);
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q      <= gble_pkg::op_e'(opcode_i);
            row_num_q <= row_number_i;
            max_len_q <= max_length_i;
            found_q   <= 1'b0;
            begin_q   <= '0;
            finish_q  <= '0;
            char_q    <= '0;
            cvalid_q  <= 1'b0;
            len_q     <= '0;
            last_q    <= 1'b1;
            full_q    <= 1'b0;
            li_q      <= '0;
            start_q   <= '0;
            cnt_q     <= (gble_pkg::op_e'(opcode_i) == gble_pkg::OP_RECOUNT) ? PW'(1) : '0;
            case (gble_pkg::op_e'(opcode_i))
              gble_pkg::OP_INIT: begin
                gap_first_q <= '0;
                gap_past_q  <= BufSize;
                tally_q     <= PW'(1);
                row_q       <= '0;
                col_q       <= '0;
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
              gble_pkg::OP_INSERT: begin
                if (gap_first_q < gap_past_q) begin
                  gap_first_q <= gap_first_q + 1'b1;
                end else begin
                  full_q <= 1'b1;
                end
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
              gble_pkg::OP_MOVE: begin
                tgt_q   <= tgt_in;
                state_q <= S_MOVE_RD;
              end
              gble_pkg::OP_RANGE, gble_pkg::OP_GETLINE,
              gble_pkg::OP_RECOUNT, gble_pkg::OP_CURSOR: begin
                state_q <= S_SCAN_RD;
              end
              default: begin
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
            endcase
          end
        end
        // Move one byte across the gap per read and write pair.
        S_MOVE_RD: begin
          if (tgt_q == gap_first_q) begin
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_MOVE_WR;
          end
        end
        S_MOVE_WR: begin
          if (tgt_q < gap_first_q) begin
            gap_first_q <= gap_first_q - 1'b1;
            gap_past_q  <= gap_past_q - 1'b1;
          end else begin
            gap_first_q <= gap_first_q + 1'b1;
            gap_past_q  <= gap_past_q + 1'b1;
          end
          state_q <= S_MOVE_RD;
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_EV;
        end
        // Examine one logical position of the text.
        S_SCAN_EV: begin
          li_q    <= li_q + 1'b1;
          state_q <= S_SCAN_RD;
          unique case (op_q)
            gble_pkg::OP_RECOUNT: begin
              if (li_q == text_len) begin
                tally_q     <= cnt_q;
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end else if (rd_data == gble_pkg::NewlineByte) begin
                cnt_q <= cnt_q + 1'b1;
              end
            end
            gble_pkg::OP_CURSOR: begin
              if (brk) begin
                if (li_q >= gap_first_q) begin
                  row_q       <= cnt_q;
                  col_q       <= gap_first_q - start_q;
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  cnt_q   <= cnt_q + 1'b1;
                  start_q <= li_q + 1'b1;
                end
              end
            end
            default: begin
              if (brk) begin
                if (XW'(cnt_q) == XW'(row_num_q)) begin
                  found_q  <= 1'b1;
                  begin_q  <= start_q;
                  finish_q <= li_q;
                  if ((op_q == gble_pkg::OP_GETLINE) && (cap != '0)) begin
                    len_q    <= LW'(cap);
                    cvalid_q <= 1'b1;
                    j_q      <= '0;
                    state_q  <= S_EMIT_RD;
                  end else begin
                    out_valid_q <= 1'b1;
                    state_q     <= S_OUT;
                  end
                end else if (li_q == text_len) begin
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  cnt_q   <= cnt_q + 1'b1;
                  start_q <= li_q + 1'b1;
                end
              end
            end
          endcase
        end
        // Fetch one byte of the line for the next result.
        S_EMIT_RD: begin
          state_q <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          char_q      <= rd_data;
          last_q      <= ((j_q + 1'b1) == len_q);
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        // Hold the result until the output side takes it.
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (cvalid_q && !last_q) begin
              j_q     <= j_q + 1'b1;
              state_q <= S_EMIT_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Output ports.
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign line_found_o   = found_q;
  assign line_begin_o   = gble_pkg::PosW'(begin_q);
  assign line_finish_o  = gble_pkg::PosW'(finish_q);
  assign char_out_o     = char_q;
  assign char_valid_o   = cvalid_q;
  assign line_length_o  = len_q;
  assign last_o         = last_q;
  assign cursor_row_o   = gble_pkg::PosW'(row_q);
  assign cursor_col_o   = gble_pkg::PosW'(col_q);
  assign line_total_o   = gble_pkg::PosW'(tally_q);
  assign gap_position_o = gble_pkg::PosW'(gap_first_q);
  assign buffer_full_o  = full_q;

endmodule

### rtl/core/gble_text_ram.sv
// ----------------------------------------------------------------------------
// gble_text_ram
// Single-port-write, single-port-read text memory with registered read data.
// ----------------------------------------------------------------------------
module gble_text_ram #(
  parameter int unsigned Depth = gble_pkg::BufferBytesDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [gble_pkg::ByteW-1:0] wr_data_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [gble_pkg::ByteW-1:0] rd_data_o
);

  logic [gble_pkg::ByteW-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data valid in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
